// ----- rtl/core/flash_address_translate_macros.svh -----
// assertion helpers used by the rtl
`ifndef FLASH_ADDRESS_TRANSLATE_MACROS_SVH
`define FLASH_ADDRESS_TRANSLATE_MACROS_SVH

// same-cycle implication
`define FAT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define FAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/core/fat_pkg.sv -----
`default_nettype none
package fat_pkg;

   // radix divisions and their pipelining
   localparam int NUM_DIV    = 6;
   localparam int DIV_BITS   = 4;
   localparam int UNIT_W     = 32;
   localparam int DIV_STAGES = UNIT_W / DIV_BITS;
   localparam int RAD_W      = 13;
   localparam int SEG_STAGES = DIV_STAGES + 1;
   localparam int CHAIN_LEN  = NUM_DIV * SEG_STAGES;

   // boundary step after which compose holds the page number
   localparam logic [2:0] PPN_STEP = 3'd4;
   localparam logic [2:0] LAST_SLOT = 3'd5;

   // request kinds
   localparam logic MODE_COMPOSE   = 1'b0;
   localparam logic MODE_DECOMPOSE = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_SUBPAGES = 3'd0;
   localparam logic [2:0] CSR_PAGES    = 3'd1;
   localparam logic [2:0] CSR_BLOCKS   = 3'd2;
   localparam logic [2:0] CSR_PLANES   = 3'd3;
   localparam logic [2:0] CSR_DIES     = 3'd4;
   localparam logic [2:0] CSR_CHIPS    = 3'd5;
   localparam logic [2:0] CSR_CHANS    = 3'd6;

   // location slots: subpage, page, block, plane, die, chip
   localparam int SLOT_SUB   = 0;
   localparam int SLOT_PAGE  = 1;
   localparam int SLOT_BLOCK = 2;
   localparam int SLOT_PLANE = 3;
   localparam int SLOT_DIE   = 4;
   localparam int SLOT_CHIP  = 5;

   // one request in flight
   typedef struct packed {
      logic                          mode;
      logic                          flag;
      logic [UNIT_W-1:0]             num;
      logic [RAD_W-1:0]              rem;
      logic [NUM_DIV-1:0][RAD_W-1:0] loc;
      logic [4:0]                    ch_in;
      logic [UNIT_W-1:0]             unit;
      logic [UNIT_W-1:0]             ppn;
   } fat_item_type;

   // per-boundary control
   typedef struct packed {
      logic [2:0]       slot;
      logic [RAD_W-1:0] mult;
   } fat_bnd_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/core/fat_div_stage.sv -----
`default_nettype none
module fat_div_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  fat_pkg::fat_item_type     in_item,
   input  wire logic [12:0]          divisor,
   output logic                      out_valid,
   output fat_pkg::fat_item_type     out_item
);
   import fat_pkg::*;

   logic         valid_ff;
   fat_item_type item_ff;
   fat_item_type item_in;
   logic [RAD_W:0] trial;

   // restoring division, a few quotient bits per stage
   always_comb begin
      item_in = in_item;
      trial   = '0;
      if (in_item.mode == MODE_DECOMPOSE) begin
         for (int i = 0; i < DIV_BITS; i++) begin
            trial = {item_in.rem, item_in.num[UNIT_W-1]};
            if (trial >= {1'b0, divisor}) begin
               trial       = trial - {1'b0, divisor};
               item_in.num = {item_in.num[UNIT_W-2:0], 1'b1};
            end else begin
               item_in.num = {item_in.num[UNIT_W-2:0], 1'b0};
            end
            item_in.rem = trial[RAD_W-1:0];
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ----- rtl/core/fat_bnd_stage.sv -----
`default_nettype none
module fat_bnd_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  fat_pkg::fat_item_type     in_item,
   input  fat_pkg::fat_bnd_ctl_type ctl,
   output logic                      out_valid,
   output fat_pkg::fat_item_type     out_item
);
   import fat_pkg::*;

   logic                valid_ff;
   fat_item_type        item_ff;
   fat_item_type        item_in;
   logic [RAD_W-1:0]    addend;
   logic [UNIT_W+RAD_W-1:0] prod;

   // compose multiplies in the next radix and adds the next field, decompose files the remainder
   always_comb begin
      item_in = in_item;
      addend  = in_item.loc[LAST_SLOT - ctl.slot];
      prod    = {{RAD_W{1'b0}}, in_item.num} * {{UNIT_W{1'b0}}, ctl.mult};
      if (in_item.mode == MODE_DECOMPOSE) begin
         item_in.loc[ctl.slot] = in_item.rem;
         item_in.rem           = '0;
         if (ctl.slot == 3'd0) begin
            item_in.ppn = in_item.num;
         end
      end else begin
         item_in.num = prod[UNIT_W-1:0] + {{(UNIT_W-RAD_W){1'b0}}, addend};
         if (ctl.slot == PPN_STEP) begin
            item_in.ppn = item_in.num;
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ----- rtl/core/flash_address_translate.sv -----
`default_nettype none
`include "flash_address_translate_macros.svh"
// Flash address translation between a flat subpage unit number and a
// channel/chip/die/plane/block/page/subpage location. The radices come from
// seven registers written over the csr port (a zero count acts as one).
// A request of kind 0 composes the location into unit and page numbers
// (wrapping at 2^32); kind 1 decomposes a unit number. One request is taken
// every cycle unless the result side stalls. The path is an input register,
// six chained restoring dividers, each cut into eight stages of four quotient
// bits plus one stage that files the remainder and does one multiply-add of
// the compose path, and an output register. A stall on the result side holds
// the whole pipeline. csr_ready is always high; the user must change registers
// only while no request is in flight; the block itself does not enforce it.
module flash_address_translate (
   input  wire logic          clock,
   input  wire logic          reset,
   // unit_in, channel_in, chip_in, die_in, plane_in, block_in, page_in,
   // subpage_in, zero fill
   input  wire logic [79:0]   req_tdata,
   // mode
   input  wire logic          req_tuser,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // unit_out, page_number, channel_out, chip_out, die_out, plane_out,
   // block_out, page_out, subpage_out, zero fill
   output logic [111:0]       rsp_tdata,
   // out_of_range
   output logic               rsp_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [12:0]   csr_data
);
   import fat_pkg::*;

   // configuration registers
   logic [4:0]  subs_ff;
   logic [10:0] pages_ff;
   logic [12:0] blocks_ff;
   logic [3:0]  planes_ff;
   logic [3:0]  dies_ff;
   logic [4:0]  chips_ff;
   logic [5:0]  chans_ff;

   logic [NUM_DIV-1:0][RAD_W-1:0] radix;
   logic [5:0]  chans_eff;

   logic         advance;
   fat_item_type in_item;
   fat_item_type stg_item [CHAIN_LEN+1];
   logic         stg_valid [CHAIN_LEN+1];

   fat_item_type last;
   logic [UNIT_W-1:0] ch_full;
   logic [5:0]  ch_six;
   logic        flag_fin;
   logic [4:0]  ch_fin;
   logic [NUM_DIV-1:0][RAD_W-1:0] loc_fin;

   logic         out_valid_ff;
   logic         out_mode_ff;
   logic [111:0] out_data_ff;
   logic [111:0] out_data_in;
   logic         out_flag_ff;

   // register writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         subs_ff   <= 5'd4;
         pages_ff  <= 11'd256;
         blocks_ff <= 13'd1024;
         planes_ff <= 4'd2;
         dies_ff   <= 4'd2;
         chips_ff  <= 5'd4;
         chans_ff  <= 6'd8;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SUBPAGES: subs_ff   <= csr_data[4:0];
            CSR_PAGES:    pages_ff  <= csr_data[10:0];
            CSR_BLOCKS:   blocks_ff <= csr_data;
            CSR_PLANES:   planes_ff <= csr_data[3:0];
            CSR_DIES:     dies_ff   <= csr_data[3:0];
            CSR_CHIPS:    chips_ff  <= csr_data[4:0];
            CSR_CHANS:    chans_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // effective radices, zero counts as one, in decompose order
   always_comb begin
      radix[SLOT_SUB]   = (subs_ff == '0)   ? 13'd1 : {8'd0, subs_ff};
      radix[SLOT_PAGE]  = (pages_ff == '0)  ? 13'd1 : {2'd0, pages_ff};
      radix[SLOT_BLOCK] = (blocks_ff == '0) ? 13'd1 : blocks_ff;
      radix[SLOT_PLANE] = (planes_ff == '0) ? 13'd1 : {9'd0, planes_ff};
      radix[SLOT_DIE]   = (dies_ff == '0)   ? 13'd1 : {9'd0, dies_ff};
      radix[SLOT_CHIP]  = (chips_ff == '0)  ? 13'd1 : {8'd0, chips_ff};
      chans_eff         = (chans_ff == '0)  ? 6'd1  : chans_ff;
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // request unpacking and compose range check
   always_comb begin
      in_item                  = '0;
      in_item.mode             = req_tuser;
      in_item.unit             = req_tdata[31:0];
      in_item.ch_in            = req_tdata[36:32];
      in_item.loc[SLOT_CHIP]   = {9'd0, req_tdata[40:37]};
      in_item.loc[SLOT_DIE]    = {10'd0, req_tdata[43:41]};
      in_item.loc[SLOT_PLANE]  = {10'd0, req_tdata[46:44]};
      in_item.loc[SLOT_BLOCK]  = {1'b0, req_tdata[58:47]};
      in_item.loc[SLOT_PAGE]   = {3'd0, req_tdata[68:59]};
      in_item.loc[SLOT_SUB]    = {9'd0, req_tdata[72:69]};
      if (req_tuser == MODE_DECOMPOSE) begin
         in_item.num = req_tdata[31:0];
      end else begin
         in_item.num = {27'd0, req_tdata[36:32]};
         for (int i = 0; i < NUM_DIV; i++) begin
            if (in_item.loc[i] >= radix[i]) begin
               in_item.flag = 1'b1;
            end
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid[0] <= 1'b0;
      end else if (advance) begin
         stg_valid[0] <= req_tvalid;
      end
      if (advance) begin
         stg_item[0] <= in_item;
      end
   end

   // six division segments, each closed by a boundary stage
   for (genvar j = 0; j < NUM_DIV; j++) begin : g_seg
      localparam int BASE = j * SEG_STAGES;
      fat_bnd_ctl_type ctl;
      assign ctl.slot = 3'(j);
      assign ctl.mult = radix[NUM_DIV-1-j];
      for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
         fat_div_stage u_div (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_valid  (stg_valid[BASE+k]),
            .in_item   (stg_item[BASE+k]),
            .divisor   (radix[j]),
            .out_valid (stg_valid[BASE+k+1]),
            .out_item  (stg_item[BASE+k+1])
         );
      end
      fat_bnd_stage u_bnd (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stg_valid[BASE+DIV_STAGES]),
         .in_item   (stg_item[BASE+DIV_STAGES]),
         .ctl       (ctl),
         .out_valid (stg_valid[BASE+SEG_STAGES]),
         .out_item  (stg_item[BASE+SEG_STAGES])
      );
   end

   // field clamps and channel saturation
   assign last = stg_item[CHAIN_LEN];
   always_comb begin
      flag_fin = last.flag;
      loc_fin  = last.loc;
      if (last.mode == MODE_DECOMPOSE) begin
         if (loc_fin[SLOT_SUB] > 13'd15) begin
            loc_fin[SLOT_SUB] = 13'd15;
            flag_fin = 1'b1;
         end
         if (loc_fin[SLOT_PAGE] > 13'd1023) begin
            loc_fin[SLOT_PAGE] = 13'd1023;
            flag_fin = 1'b1;
         end
         if (loc_fin[SLOT_BLOCK] > 13'd4095) begin
            loc_fin[SLOT_BLOCK] = 13'd4095;
            flag_fin = 1'b1;
         end
         if (loc_fin[SLOT_PLANE] > 13'd7) begin
            loc_fin[SLOT_PLANE] = 13'd7;
            flag_fin = 1'b1;
         end
         if (loc_fin[SLOT_DIE] > 13'd7) begin
            loc_fin[SLOT_DIE] = 13'd7;
            flag_fin = 1'b1;
         end
         if (loc_fin[SLOT_CHIP] > 13'd15) begin
            loc_fin[SLOT_CHIP] = 13'd15;
            flag_fin = 1'b1;
         end
         ch_full = last.num;
      end else begin
         ch_full = {27'd0, last.ch_in};
      end
      if (ch_full >= {26'd0, chans_eff}) begin
         ch_six   = chans_eff - 6'd1;
         flag_fin = 1'b1;
      end else begin
         ch_six = ch_full[5:0];
      end
      if (ch_six > 6'd31) begin
         ch_fin   = 5'd31;
         flag_fin = 1'b1;
      end else begin
         ch_fin = ch_six[4:0];
      end
   end

   // result packing
   always_comb begin
      out_data_in           = '0;
      out_data_in[31:0]     = (last.mode == MODE_DECOMPOSE) ? last.unit : last.num;
      out_data_in[63:32]    = last.ppn;
      out_data_in[68:64]    = ch_fin;
      out_data_in[72:69]    = loc_fin[SLOT_CHIP][3:0];
      out_data_in[75:73]    = loc_fin[SLOT_DIE][2:0];
      out_data_in[78:76]    = loc_fin[SLOT_PLANE][2:0];
      out_data_in[90:79]    = loc_fin[SLOT_BLOCK][11:0];
      out_data_in[100:91]   = loc_fin[SLOT_PAGE][9:0];
      out_data_in[104:101]  = loc_fin[SLOT_SUB][3:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stg_valid[CHAIN_LEN];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_flag_ff <= flag_fin;
         out_mode_ff <= last.mode;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_flag_ff;

   // checks
   `FAT_ASSERT_IMPLY(a_ch_sat, clock, reset, rsp_tvalid, {1'b0, rsp_tdata[68:64]} < chans_eff)
   `FAT_ASSERT_IMPLY(a_sub_ok, clock, reset, rsp_tvalid && out_mode_ff == MODE_DECOMPOSE && !rsp_tuser, {9'd0, rsp_tdata[104:101]} < radix[SLOT_SUB])
   `FAT_ASSERT_IMPLY(a_chip_ok, clock, reset, rsp_tvalid && out_mode_ff == MODE_COMPOSE && !rsp_tuser, {9'd0, rsp_tdata[72:69]} < radix[SLOT_CHIP])
   `FAT_ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, stg_valid[0])

endmodule
`default_nettype wire
